// File: design/sra_pkg.sv
`timescale 1ns / 1ps

package sra_pkg;

  // field widths fixed by the stream words
  localparam int FIELD_W     = 11;
  localparam int POS_W       = 10;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  typedef struct packed {
    logic [FIELD_W-1:0] region_height;
    logic [FIELD_W-1:0] region_width;
    op_t                opcode;
  } cmd_t;

  typedef struct packed {
    logic             placed;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_x;
  } res_t;

endpackage

// File: design/skyline_rect_allocator_unit.sv
`timescale 1ns / 1ps

// skyline bottom-left rectangle allocator for one square page of PAGE_SIZE columns: each
// column keeps its first free row in an on-chip memory; an allocate word (tuser 0) brings a
// width and a height and returns one result word with x, y and a placed flag, choosing the
// lowest base over all start columns where the height steps (leftmost on ties) and raising
// the covered columns; a clear word (tuser 1) zeroes every column and returns nothing. one
// item is worked at a time. in an allocation, a backward pass over the height memory builds
// block suffix maxima of the window width in a second memory, a forward pass reads both
// memories to get each window's maximum, and, once the result is loaded, a write pass
// updates the placed columns. a word whose size is zero or larger than the page has its
// result loaded without a scan. after reset a clearing pass over every column runs before
// the first word is taken. a result waits while the output register is full, which stalls
// the next word; once it moves into the output register the next word is taken while it
// waits (after the write pass, for a placed result).

module skyline_rect_allocator_unit #(
  parameter int PAGE_SIZE = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input words
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [sra_pkg::IN_TDATA_W-1:0]     in_tdata,   // region_width [10:0], region_height [21:11]
  input  logic                               in_tuser,   // opcode
  // result words
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [sra_pkg::OUT_TDATA_W-1:0]    out_tdata,  // pos_x [9:0], pos_y [19:10]
  output logic                               out_tuser   // placed
);

  localparam int FW = sra_pkg::FIELD_W;
  localparam int PW = sra_pkg::POS_W;

  sra_pkg::cmd_t cmd;
  sra_pkg::res_t res;
  logic          scan_idle;
  logic          res_valid;
  logic          res_ready;
  logic          start;

  logic                            out_tvalid_r, out_tvalid_nxt;
  logic [sra_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic                            out_tuser_r, out_tuser_nxt;

  // unpack the input word
  always_comb begin
    cmd.opcode        = sra_pkg::op_t'(in_tuser);
    cmd.region_width  = in_tdata[FW-1:0];
    cmd.region_height = in_tdata[2*FW-1:FW];
  end

  // the scanner takes a word only when it has nothing in flight
  assign in_tready = scan_idle;
  assign start     = in_tvalid && in_tready;

  sra_scan #(
    .PAGE_SIZE(PAGE_SIZE)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .cmd      (cmd),
    .idle     (scan_idle),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // output register: free when empty or being drained this cycle
  assign res_ready = !out_tvalid_r || out_tready;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    if (res_valid && res_ready) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {{(sra_pkg::OUT_TDATA_W - 2*PW){1'b0}}, res.pos_y, res.pos_x};
      out_tuser_nxt  = res.placed;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// File: design/sra_ram.sv
`timescale 1ns / 1ps

module sra_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/sra_scan.sv
`timescale 1ns / 1ps

module sra_scan #(
  parameter int PAGE_SIZE = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  sra_pkg::cmd_t cmd,
  output logic          idle,
  output logic          res_valid,
  input  logic          res_ready,
  output sra_pkg::res_t res
);

  localparam int AW = $clog2(PAGE_SIZE);
  localparam int HW = $clog2(PAGE_SIZE + 1);
  localparam int CW = (HW > sra_pkg::FIELD_W) ? HW : sra_pkg::FIELD_W;
  localparam logic [AW-1:0] LAST_COL = AW'(PAGE_SIZE - 1);
  localparam logic [HW-1:0] PAGE_H   = HW'(PAGE_SIZE);
  localparam logic [CW-1:0] PAGE_C   = CW'(PAGE_SIZE);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BACK,
    ST_FWD,
    ST_RESULT,
    ST_WRITE
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] blk_r, blk_nxt;
  logic          iss_done_r, iss_done_nxt;
  logic [AW-1:0] w_m1_r, w_m1_nxt;
  logic [HW-1:0] h_r, h_nxt;
  logic [HW-1:0] limit_r, limit_nxt;
  logic          p1_v_r, p1_v_nxt;
  logic [AW-1:0] p1_j_r, p1_j_nxt;
  logic [AW-1:0] p1_b_r, p1_b_nxt;
  logic          p2_v_r, p2_v_nxt;
  logic [AW-1:0] p2_x_r, p2_x_nxt;
  logic [HW-1:0] p2_base_r, p2_base_nxt;
  logic          p2_cand_r, p2_cand_nxt;
  logic          found_r, found_nxt;
  logic [AW-1:0] best_x_r, best_x_nxt;
  logic [HW-1:0] best_y_r, best_y_nxt;
  logic [HW-1:0] suf_r, suf_nxt;
  logic [HW-1:0] pre_r, pre_nxt;
  logic [HW-1:0] prev_h_r, prev_h_nxt;

  logic          h_we;
  logic [AW-1:0] h_waddr, h_raddr;
  logic [HW-1:0] h_wdata, h_rdata;
  logic          s_we;
  logic [AW-1:0] s_waddr, s_raddr;
  logic [HW:0]   s_wdata, s_rdata;

  logic [CW-1:0] width_c, height_c;
  logic          size_ok;
  logic          issue;
  logic          back_done, fwd_done;
  logic [HW-1:0] hv, s_val;
  logic          s_cand;
  logic [HW-1:0] suf_max, suf_new, pre_max, pre_new, win_base;
  logic          blk_start, win_ok, better;

  // column heights
  sra_ram #(
    .DEPTH(PAGE_SIZE),
    .WIDTH(HW)
  ) u_height_ram (
    .clk  (clk),
    .we   (h_we),
    .waddr(h_waddr),
    .wdata(h_wdata),
    .raddr(h_raddr),
    .rdata(h_rdata)
  );

  // per column: block suffix max and start-candidate bit (lsb)
  sra_ram #(
    .DEPTH(PAGE_SIZE),
    .WIDTH(HW + 1)
  ) u_suffix_ram (
    .clk  (clk),
    .we   (s_we),
    .waddr(s_waddr),
    .wdata(s_wdata),
    .raddr(s_raddr),
    .rdata(s_rdata)
  );

  always_comb begin
    width_c  = CW'(cmd.region_width);
    height_c = CW'(cmd.region_height);
    size_ok  = (width_c != '0) && (height_c != '0) &&
               (width_c <= PAGE_C) && (height_c <= PAGE_C);

    issue     = ((state_r == ST_BACK) || (state_r == ST_FWD)) && !iss_done_r;
    back_done = (state_r == ST_BACK) && iss_done_r && !p1_v_r;
    fwd_done  = (state_r == ST_FWD) && iss_done_r && !p1_v_r && !p2_v_r;

    hv     = h_rdata;
    s_val  = s_rdata[HW:1];
    s_cand = s_rdata[0];

    suf_max   = (suf_r > hv) ? suf_r : hv;
    suf_new   = (p1_b_r == '0) ? hv : suf_max;
    blk_start = (p1_j_r == '0) || (p1_b_r == w_m1_r);
    pre_max   = (pre_r > hv) ? pre_r : hv;
    pre_new   = blk_start ? hv : pre_max;
    win_base  = (s_val > pre_new) ? s_val : pre_new;
    win_ok    = p1_j_r >= w_m1_r;
    better    = p2_v_r && p2_cand_r && (p2_base_r <= limit_r) &&
                (!found_r || (p2_base_r < best_y_r));

    h_raddr = cnt_r;
    s_raddr = cnt_r - w_m1_r;
    h_we    = (state_r == ST_CLEAR) || (state_r == ST_WRITE);
    h_waddr = (state_r == ST_CLEAR) ? cnt_r : best_x_r + cnt_r;
    h_wdata = (state_r == ST_CLEAR) ? '0 : best_y_r + h_r;
    s_we    = (state_r == ST_BACK) && ((p1_v_r && (p1_j_r != LAST_COL)) || back_done);
    s_waddr = back_done ? '0 : p1_j_r + AW'(1);
    s_wdata = back_done ? {suf_r, 1'b1} : {suf_r, (hv != prev_h_r)};
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    blk_nxt      = blk_r;
    iss_done_nxt = iss_done_r;
    w_m1_nxt     = w_m1_r;
    h_nxt        = h_r;
    limit_nxt    = limit_r;
    p1_v_nxt     = issue;
    p1_j_nxt     = cnt_r;
    p1_b_nxt     = blk_r;
    p2_v_nxt     = 1'b0;
    p2_x_nxt     = p2_x_r;
    p2_base_nxt  = p2_base_r;
    p2_cand_nxt  = p2_cand_r;
    found_nxt    = found_r;
    best_x_nxt   = best_x_r;
    best_y_nxt   = best_y_r;
    suf_nxt      = suf_r;
    pre_nxt      = pre_r;
    prev_h_nxt   = prev_h_r;

    // read issue
    if (issue) begin
      if (state_r == ST_BACK) begin
        if (cnt_r == '0) begin
          iss_done_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r - AW'(1);
          blk_nxt = (blk_r == w_m1_r) ? '0 : blk_r + AW'(1);
        end
      end else begin
        if (cnt_r == LAST_COL) begin
          iss_done_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
          blk_nxt = (blk_r == '0) ? w_m1_r : blk_r - AW'(1);
        end
      end
    end

    // read data stage
    if (p1_v_r) begin
      if (state_r == ST_BACK) begin
        suf_nxt    = suf_new;
        prev_h_nxt = hv;
      end else begin
        pre_nxt     = pre_new;
        p2_v_nxt    = win_ok;
        p2_x_nxt    = p1_j_r - w_m1_r;
        p2_base_nxt = win_base;
        p2_cand_nxt = s_cand;
      end
    end

    // best-so-far stage
    if (better) begin
      found_nxt  = 1'b1;
      best_x_nxt = p2_x_r;
      best_y_nxt = p2_base_r;
    end

    unique case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == LAST_COL) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (cmd.opcode == sra_pkg::OP_CLEAR) begin
            state_nxt = ST_CLEAR;
            cnt_nxt   = '0;
          end else if (size_ok) begin
            state_nxt    = ST_BACK;
            cnt_nxt      = LAST_COL;
            blk_nxt      = '0;
            iss_done_nxt = 1'b0;
            found_nxt    = 1'b0;
            w_m1_nxt     = AW'(width_c - CW'(1));
            h_nxt        = HW'(height_c);
            limit_nxt    = PAGE_H - HW'(height_c);
          end else begin
            state_nxt = ST_RESULT;
            found_nxt = 1'b0;
          end
        end
      end
      ST_BACK: begin
        if (back_done) begin
          state_nxt    = ST_FWD;
          cnt_nxt      = '0;
          iss_done_nxt = 1'b0;
        end
      end
      ST_FWD: begin
        if (fwd_done) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (res_ready) begin
          state_nxt = found_r ? ST_WRITE : ST_IDLE;
          cnt_nxt   = '0;
        end
      end
      ST_WRITE: begin
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == w_m1_r) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      cnt_r      <= '0;
      iss_done_r <= 1'b0;
      p1_v_r     <= 1'b0;
      p2_v_r     <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      iss_done_r <= iss_done_nxt;
      p1_v_r     <= p1_v_nxt;
      p2_v_r     <= p2_v_nxt;
      found_r    <= found_nxt;
    end
    blk_r     <= blk_nxt;
    w_m1_r    <= w_m1_nxt;
    h_r       <= h_nxt;
    limit_r   <= limit_nxt;
    p1_j_r    <= p1_j_nxt;
    p1_b_r    <= p1_b_nxt;
    p2_x_r    <= p2_x_nxt;
    p2_base_r <= p2_base_nxt;
    p2_cand_r <= p2_cand_nxt;
    best_x_r  <= best_x_nxt;
    best_y_r  <= best_y_nxt;
    suf_r     <= suf_nxt;
    pre_r     <= pre_nxt;
    prev_h_r  <= prev_h_nxt;
  end

  assign idle       = (state_r == ST_IDLE);
  assign res_valid  = (state_r == ST_RESULT);
  assign res.placed = found_r;
  assign res.pos_x  = found_r ? sra_pkg::POS_W'(best_x_r) : '0;
  assign res.pos_y  = found_r ? sra_pkg::POS_W'(best_y_r) : '0;

endmodule
